// ===== design/nss_pkg.sv =====
package nss_pkg;

   localparam int COORD_BITS    = 16;
   localparam int INDEX_BITS    = 10;
   localparam int THRESH_BITS   = 16;
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int MAX_SEGMENTS  = 1024;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd160;
   localparam logic [MODE_BITS-1:0]   MODE_RESET   = 2'd1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE      = 1'b1;

   localparam logic [MODE_BITS-1:0] MODE_ENDPOINT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_NEAREST  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MIDPOINT = 2'd2;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ENDS,
      KIND_PROJ,
      KIND_MID
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_PROD,
      ST_SUM,
      ST_CLAMP,
      ST_MUL,
      ST_DIV,
      ST_DSQ,
      ST_OFFER,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] qx;
      logic signed [COORD_BITS-1:0] qy;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      kind_type                     kind;
      logic                         last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic                         found;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [INDEX_BITS-1:0]        index;
      logic                         at_end;
   } rsp_type;

endpackage

// ===== design/nss_ifs.sv =====
interface nss_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [nss_pkg::COORD_BITS-1:0] query_x;
   logic signed [nss_pkg::COORD_BITS-1:0] query_y;
   logic signed [nss_pkg::COORD_BITS-1:0] start_x;
   logic signed [nss_pkg::COORD_BITS-1:0] start_y;
   logic signed [nss_pkg::COORD_BITS-1:0] end_x;
   logic signed [nss_pkg::COORD_BITS-1:0] end_y;
   logic                                  skip_segment;
   logic                                  last_segment;

   modport source (output valid, query_x, query_y, start_x, start_y, end_x, end_y,
                   skip_segment, last_segment, input ready);
   modport sink (input valid, query_x, query_y, start_x, start_y, end_x, end_y,
                 skip_segment, last_segment, output ready);
endinterface

interface nss_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  snap_found;
   logic signed [nss_pkg::COORD_BITS-1:0] snap_x;
   logic signed [nss_pkg::COORD_BITS-1:0] snap_y;
   logic [nss_pkg::INDEX_BITS-1:0]        segment_index;
   logic                                  at_end_point;

   modport source (output valid, snap_found, snap_x, snap_y, segment_index, at_end_point,
                   input ready);
   modport sink (input valid, snap_found, snap_x, snap_y, segment_index, at_end_point,
                 output ready);
endinterface

interface nss_csr_if;
   logic                               valid;
   logic                               ready;
   logic [nss_pkg::CSR_IDX_BITS-1:0]   index;
   logic [nss_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/nss_front.sv =====
module nss_front (
   input  logic                           clock,
   input  logic                           reset,
   nss_req_if.sink                        req_if,
   input  logic [nss_pkg::MODE_BITS-1:0]  mode,
   output nss_pkg::queue_type             head,
   input  logic                           pop
);

   localparam int PTR_BITS = (nss_pkg::QUEUE_DEPTH > 1) ? $clog2(nss_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(nss_pkg::QUEUE_DEPTH + 1);

   nss_pkg::item_type     mem_ff [nss_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   nss_pkg::item_type     item;
   logic                  push;
   logic                  do_pop;

   // classify the request
   always_comb begin
      item.qx   = req_if.query_x;
      item.qy   = req_if.query_y;
      item.ax   = req_if.start_x;
      item.ay   = req_if.start_y;
      item.bx   = req_if.end_x;
      item.by   = req_if.end_y;
      item.last = req_if.last_segment;
      if (req_if.skip_segment) begin
         item.kind = nss_pkg::KIND_NONE;
      end else begin
         unique case (mode)
            nss_pkg::MODE_ENDPOINT: item.kind = nss_pkg::KIND_ENDS;
            nss_pkg::MODE_NEAREST:  item.kind = nss_pkg::KIND_PROJ;
            nss_pkg::MODE_MIDPOINT: item.kind = nss_pkg::KIND_MID;
            default:                item.kind = nss_pkg::KIND_NONE;
         endcase
      end
   end

   assign req_if.ready = (count_ff != CNT_BITS'(nss_pkg::QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign do_pop       = pop && head.valid;
   assign head.valid   = (count_ff != '0);
   assign head.item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(nss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(nss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== design/nss_back.sv =====
module nss_back #(
   parameter int MAX_SEGMENTS = nss_pkg::MAX_SEGMENTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nss_pkg::queue_type               head,
   output logic                             pop,
   input  logic [nss_pkg::THRESH_BITS-1:0]  threshold,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output nss_pkg::rsp_type                 rsp
);

   localparam int CW   = nss_pkg::COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int LW   = 2 * CW + 1;
   localparam int DOTW = LW + 2;
   localparam int NW   = CW + LW;
   localparam int RW   = NW + 2;
   localparam int SQW  = 2 * DW;
   localparam int BW   = SQW + 1;
   localparam int TW   = 2 * nss_pkg::THRESH_BITS;
   localparam int QB   = $clog2(CW);
   localparam int POSW = $clog2(MAX_SEGMENTS);

   nss_pkg::state_type           state_ff, state_in;
   nss_pkg::item_type            item_ff, item_in;
   logic signed [DW-1:0]         dx_ff, dx_in, dy_ff, dy_in, ux_ff, ux_in, uy_ff, uy_in;
   logic signed [PW-1:0]         pxx_ff, pxx_in, pyy_ff, pyy_in, lxx_ff, lxx_in, lyy_ff, lyy_in;
   logic signed [DOTW-1:0]       dot_ff, dot_in;
   logic [LW-1:0]                len2_ff, len2_in;
   logic                         axis_ff, axis_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [CW-1:0]                q_ff, q_in;
   logic [QB-1:0]                bit_ff, bit_in;
   logic signed [CW-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic                         cend_ff, cend_in;
   logic [SQW-1:0]               sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [TW-1:0]                thr2_ff, thr2_in;
   logic [BW-1:0]                best_d_ff, best_d_in;
   logic signed [CW-1:0]         best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [nss_pkg::INDEX_BITS-1:0] best_idx_ff, best_idx_in;
   logic                         best_end_ff, best_end_in;
   logic                         any_ff, any_in;
   logic [POSW-1:0]              pos_ff, pos_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   nss_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [DW-1:0]         d_axis;
   logic [CW-1:0]                mag;
   logic [NW-1:0]                prod_n;
   logic [RW-1:0]                shifted;
   logic [CW-1:0]                q_next;
   logic signed [DW-1:0]         offset;
   logic signed [DW-1:0]         p_axis;
   logic signed [DW-1:0]         ex, ey;
   logic [BW-1:0]                dist_sum;
   logic                         take;

   assign pop       = (state_ff == nss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // projection datapath helpers
   always_comb begin
      d_axis   = axis_ff ? dy_ff : dx_ff;
      mag      = d_axis[DW-1] ? CW'(-d_axis) : CW'(d_axis);
      prod_n   = NW'(mag) * NW'(dot_ff[LW-1:0]);
      shifted  = RW'({len2_ff, 1'b0}) << bit_ff;
      q_next   = q_ff;
      if (rem_ff >= shifted) begin
         q_next[bit_ff] = 1'b1;
      end
      offset   = d_axis[DW-1] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
      p_axis   = (axis_ff ? DW'(item_ff.ay) : DW'(item_ff.ax)) + offset;
      ex       = DW'(cx_ff) - DW'(item_ff.qx);
      ey       = DW'(cy_ff) - DW'(item_ff.qy);
      dist_sum = BW'(sqx_ff) + BW'(sqy_ff);
      take     = (dist_sum < BW'(thr2_ff)) && (!any_ff || dist_sum < best_d_ff);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      pxx_in       = pxx_ff;
      pyy_in       = pyy_ff;
      lxx_in       = lxx_ff;
      lyy_in       = lyy_ff;
      dot_in       = dot_ff;
      len2_in      = len2_ff;
      axis_in      = axis_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cend_in      = cend_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      thr2_in      = thr2_ff;
      best_d_in    = best_d_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      best_idx_in  = best_idx_ff;
      best_end_in  = best_end_ff;
      any_in       = any_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         nss_pkg::ST_IDLE: begin
            if (head.valid) begin
               item_in = head.item;
               cx_in   = head.item.ax;
               cy_in   = head.item.ay;
               cend_in = 1'b0;
               unique case (head.item.kind)
                  nss_pkg::KIND_ENDS: state_in = nss_pkg::ST_DSQ;
                  nss_pkg::KIND_PROJ: state_in = nss_pkg::ST_DIFF;
                  nss_pkg::KIND_MID: begin
                     cx_in    = CW'((DW'(head.item.ax) + DW'(head.item.bx)) >>> 1);
                     cy_in    = CW'((DW'(head.item.ay) + DW'(head.item.by)) >>> 1);
                     state_in = nss_pkg::ST_DSQ;
                  end
                  default: state_in = nss_pkg::ST_FIN;
               endcase
            end
         end
         nss_pkg::ST_DIFF: begin
            dx_in    = DW'(item_ff.bx) - DW'(item_ff.ax);
            dy_in    = DW'(item_ff.by) - DW'(item_ff.ay);
            ux_in    = DW'(item_ff.qx) - DW'(item_ff.ax);
            uy_in    = DW'(item_ff.qy) - DW'(item_ff.ay);
            state_in = nss_pkg::ST_PROD;
         end
         nss_pkg::ST_PROD: begin
            pxx_in   = PW'(ux_ff) * PW'(dx_ff);
            pyy_in   = PW'(uy_ff) * PW'(dy_ff);
            lxx_in   = PW'(dx_ff) * PW'(dx_ff);
            lyy_in   = PW'(dy_ff) * PW'(dy_ff);
            state_in = nss_pkg::ST_SUM;
         end
         nss_pkg::ST_SUM: begin
            dot_in   = DOTW'(pxx_ff) + DOTW'(pyy_ff);
            len2_in  = LW'(lxx_ff) + LW'(lyy_ff);
            state_in = nss_pkg::ST_CLAMP;
         end
         nss_pkg::ST_CLAMP: begin
            axis_in = 1'b0;
            if (len2_ff == '0 || dot_ff <= 0) begin
               state_in = nss_pkg::ST_DSQ;
            end else if (dot_ff >= $signed(DOTW'(len2_ff))) begin
               cx_in    = item_ff.bx;
               cy_in    = item_ff.by;
               state_in = nss_pkg::ST_DSQ;
            end else begin
               state_in = nss_pkg::ST_MUL;
            end
         end
         nss_pkg::ST_MUL: begin
            rem_in   = RW'({prod_n, 1'b0}) + RW'(len2_ff);
            q_in     = '0;
            bit_in   = QB'(CW - 1);
            state_in = nss_pkg::ST_DIV;
         end
         nss_pkg::ST_DIV: begin
            q_in = q_next;
            if (rem_ff >= shifted) begin
               rem_in = rem_ff - shifted;
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               if (axis_ff) begin
                  cy_in    = CW'(p_axis);
                  state_in = nss_pkg::ST_DSQ;
               end else begin
                  cx_in    = CW'(p_axis);
                  axis_in  = 1'b1;
                  state_in = nss_pkg::ST_MUL;
               end
            end
         end
         nss_pkg::ST_DSQ: begin
            sqx_in   = SQW'(ex * ex);
            sqy_in   = SQW'(ey * ey);
            thr2_in  = TW'(threshold) * TW'(threshold);
            state_in = nss_pkg::ST_OFFER;
         end
         nss_pkg::ST_OFFER: begin
            if (take) begin
               best_d_in   = dist_sum;
               best_x_in   = cx_ff;
               best_y_in   = cy_ff;
               best_idx_in = nss_pkg::INDEX_BITS'(pos_ff);
               best_end_in = cend_ff;
               any_in      = 1'b1;
            end
            if (item_ff.kind == nss_pkg::KIND_ENDS && !cend_ff) begin
               cx_in    = item_ff.bx;
               cy_in    = item_ff.by;
               cend_in  = 1'b1;
               state_in = nss_pkg::ST_DSQ;
            end else begin
               state_in = nss_pkg::ST_FIN;
            end
         end
         nss_pkg::ST_FIN: begin
            if (!item_ff.last) begin
               pos_in   = (pos_ff == POSW'(MAX_SEGMENTS - 1)) ? '0 : pos_ff + 1'b1;
               state_in = nss_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.found  = any_ff;
               rsp_in.x      = any_ff ? best_x_ff : '0;
               rsp_in.y      = any_ff ? best_y_ff : '0;
               rsp_in.index  = any_ff ? best_idx_ff : '0;
               rsp_in.at_end = any_ff && best_end_ff;
               rsp_valid_in  = 1'b1;
               any_in        = 1'b0;
               pos_in        = '0;
               state_in      = nss_pkg::ST_IDLE;
            end
         end
         default: state_in = nss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nss_pkg::ST_IDLE;
         any_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         any_ff       <= any_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      pxx_ff      <= pxx_in;
      pyy_ff      <= pyy_in;
      lxx_ff      <= lxx_in;
      lyy_ff      <= lyy_in;
      dot_ff      <= dot_in;
      len2_ff     <= len2_in;
      axis_ff     <= axis_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      bit_ff      <= bit_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cend_ff     <= cend_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      thr2_ff     <= thr2_in;
      best_d_ff   <= best_d_in;
      best_x_ff   <= best_x_in;
      best_y_ff   <= best_y_in;
      best_idx_ff <= best_idx_in;
      best_end_ff <= best_end_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== design/nearest_segment_snap_core.sv =====
// Snaps a query point to the nearest candidate over a run of segments; one result per run,
// on the segment flagged last. Requests enter a two-entry queue and are worked one at a
// time by a sequencer: a skipped segment offers no candidate, while midpoint and endpoint modes do
// one distance and compare per candidate; nearest-point mode skips the division when the
// projection clamps to an end or the segment is degenerate, and otherwise runs
// the two 16-step shift-subtract divisions of the projection. A finished result sits in an
// output register, so the next segments are taken while it waits.
module nearest_segment_snap_core #(
   parameter int MAX_SEGMENTS = nss_pkg::MAX_SEGMENTS
) (
   input  logic     clock,
   input  logic     reset,
   nss_req_if.sink  req_if,
   nss_rsp_if.source rsp_if,
   nss_csr_if.sink  csr_if
);

   logic [nss_pkg::THRESH_BITS-1:0] threshold_ff, threshold_in;
   logic [nss_pkg::MODE_BITS-1:0]   mode_ff, mode_in;
   nss_pkg::queue_type              head;
   logic                            pop;
   nss_pkg::rsp_type                rsp;
   logic                            rsp_valid;

   assign csr_if.ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      mode_in      = mode_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            nss_pkg::CSR_THRESHOLD: threshold_in = nss_pkg::THRESH_BITS'(csr_if.data);
            nss_pkg::CSR_MODE:      mode_in      = nss_pkg::MODE_BITS'(csr_if.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= nss_pkg::THRESH_RESET;
         mode_ff      <= nss_pkg::MODE_RESET;
      end else begin
         threshold_ff <= threshold_in;
         mode_ff      <= mode_in;
      end
   end

   nss_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .mode   (mode_ff),
      .head   (head),
      .pop    (pop)
   );

   nss_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .threshold (threshold_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp       (rsp)
   );

   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.snap_found    = rsp.found;
   assign rsp_if.snap_x        = rsp.x;
   assign rsp_if.snap_y        = rsp.y;
   assign rsp_if.segment_index = rsp.index;
   assign rsp_if.at_end_point  = rsp.at_end;

   // empty result carries zero payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.snap_found |->
         rsp_if.snap_x == '0 && rsp_if.snap_y == '0 && rsp_if.segment_index == '0
         && !rsp_if.at_end_point)
      else $error("empty result with nonzero payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.at_end_point |-> rsp_if.snap_found)
      else $error("end point flag without snap");

   // a pending result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_if.ready |=> rsp_valid && $stable(rsp))
      else $error("pending result lost");

endmodule
